[src/mbec_pkg.sv]
// package: shared types and constants for the environment contraction block
`default_nettype none
package mbec_pkg;
	localparam int OUT_FRAC = 14;
	localparam int ACC_W = 64;

	typedef enum logic [1:0] {
		OP_SITE  = 2'd0,
		OP_ENV   = 2'd1,
		OP_START = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_LEFT  = 2'd0,
		REG_RIGHT = 2'd1,
		REG_DIR   = 2'd2,
		REG_NONE  = 2'd3
	} reg_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_READ  = 2'd1,
		ST_DRAIN = 2'd2
	} state_t;

	// control carried alongside a term down the cell chain
	typedef struct packed {
		logic valid;
		logic first;
		logic final_term;
		logic last;
		logic [2:0] row;
		logic [2:0] col;
	} tag_t;
endpackage
`default_nettype wire

[src/mbec_cell.sv]
// cell: one complex multiply stage of the term chain
`default_nettype none
module mbec_cell #(
	parameter int AW = 16,
	parameter int BW = 16,
	parameter int PW = 33,
	parameter logic CONJ_B = 1'b0
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire mbec_pkg::tag_t tag_in,
	input  wire logic signed [AW-1:0] a_re,
	input  wire logic signed [AW-1:0] a_im,
	input  wire logic signed [BW-1:0] b_re,
	input  wire logic signed [BW-1:0] b_im,
	output mbec_pkg::tag_t tag_out,
	output logic signed [PW-1:0] p_re,
	output logic signed [PW-1:0] p_im
);
	logic signed [AW+BW-1:0] rr_s1, ii_s1, ri_s1, ir_s1;
	mbec_pkg::tag_t tag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_out <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_out <= tag_s1;
		end
	end

	// partial products registered, then combined
	always_ff @(posedge clk) begin
		rr_s1 <= a_re * b_re;
		ii_s1 <= a_im * b_im;
		ri_s1 <= a_re * b_im;
		ir_s1 <= a_im * b_re;
		if (CONJ_B) begin
			p_re <= PW'(rr_s1) + PW'(ii_s1);
			p_im <= PW'(ir_s1) - PW'(ri_s1);
		end else begin
			p_re <= PW'(rr_s1) - PW'(ii_s1);
			p_im <= PW'(ri_s1) + PW'(ir_s1);
		end
	end
endmodule
`default_nettype wire

[src/mbec_acc.sv]
// accumulator and output rescale with saturation
`default_nettype none
module mbec_acc #(
	parameter int PW = 50,
	parameter int SHIFT = 28
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire mbec_pkg::tag_t tag_in,
	input  wire logic signed [PW-1:0] t_re,
	input  wire logic signed [PW-1:0] t_im,
	output logic done,
	output logic [2:0] out_row,
	output logic [2:0] out_col,
	output logic signed [31:0] out_re,
	output logic signed [31:0] out_im,
	output logic last
);
	localparam int W = mbec_pkg::ACC_W;
	logic signed [W-1:0] acc_re_q, acc_im_q, nre, nim;

	function automatic logic signed [31:0] resc(input logic signed [W-1:0] v);
		logic signed [W-1:0] r;
		r = (v + (W'(1) <<< (SHIFT-1))) >>> SHIFT;
		if (r > W'(64'sh7fffffff)) return 32'sh7fffffff;
		else if (r < -W'(64'sh80000000)) return 32'sh80000000;
		else return r[31:0];
	endfunction

	always_comb begin
		nre = (tag_in.first ? '0 : acc_re_q) + W'(t_re);
		nim = (tag_in.first ? '0 : acc_im_q) + W'(t_im);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
			last <= 1'b0;
		end else begin
			done <= tag_in.valid && tag_in.final_term;
			last <= tag_in.valid && tag_in.final_term && tag_in.last;
		end
	end

	always_ff @(posedge clk) begin
		if (tag_in.valid) begin
			acc_re_q <= nre;
			acc_im_q <= nim;
		end
		if (tag_in.valid && tag_in.final_term) begin
			out_re <= resc(nre);
			out_im <= resc(nim);
			out_row <= tag_in.row;
			out_col <= tag_in.col;
		end
	end
endmodule
`default_nettype wire

[src/mps_bond_environment_contraction.sv]
// top level: site and environment stores, term sequencer and cell chain
// one term of the sum enters the chain per cycle: each element of the n x n result
// sums 2*inner*inner terms, and a start item keeps busy high while all terms are
// read and through the pipeline drain
// each result strobes on done for one cycle, after its last term has passed the read
// registers, both cells and the accumulator register; results cannot be stalled
// write items give no result
// asynchronous reset clears the control state and configuration registers, not the stores or the datapath registers
`default_nettype none
module mps_bond_environment_contraction #(
	parameter int DATA_WIDTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire logic [1:0] op,
	input  wire logic phys_index,
	input  wire logic [2:0] row_index,
	input  wire logic [2:0] col_index,
	input  wire logic signed [DATA_WIDTH-1:0] value_re,
	input  wire logic signed [DATA_WIDTH-1:0] value_im,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [3:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output logic done,
	output logic [2:0] out_row,
	output logic [2:0] out_col,
	output logic signed [31:0] out_re,
	output logic signed [31:0] out_im,
	output logic last
);
	localparam int DW = DATA_WIDTH;
	localparam int PW1 = 2*DW + 1;
	localparam int PW2 = PW1 + DW + 1;
	localparam int SHIFT = 3*(DW-2) - mbec_pkg::OUT_FRAC;

	// configuration registers
	logic [3:0] left_dim_q, right_dim_q;
	logic direction_q;
	mbec_pkg::reg_t reg_sel;
	assign reg_sel = mbec_pkg::reg_t'(paddr[3:2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_dim_q <= 4'd1;
			right_dim_q <= 4'd1;
			direction_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				mbec_pkg::REG_LEFT:  left_dim_q <= pwdata[3:0];
				mbec_pkg::REG_RIGHT: right_dim_q <= pwdata[3:0];
				mbec_pkg::REG_DIR:   direction_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			mbec_pkg::REG_LEFT:  prdata = {28'd0, left_dim_q};
			mbec_pkg::REG_RIGHT: prdata = {28'd0, right_dim_q};
			mbec_pkg::REG_DIR:   prdata = {31'd0, direction_q};
			default:             prdata = '0;
		endcase
	end

	// effective dimensions: zero counts as one, above eight clamps
	function automatic logic [3:0] effd(input logic [3:0] d);
		if (d == 4'd0) return 4'd1;
		else if (d > 4'd8) return 4'd8;
		else return d;
	endfunction

	logic [3:0] ldim, rdim, n_dim, inner_dim;
	assign ldim = effd(left_dim_q);
	assign rdim = effd(right_dim_q);
	assign n_dim = direction_q ? rdim : ldim;
	assign inner_dim = direction_q ? ldim : rdim;

	// stores: site is two copies so two entries can be read per cycle
	logic [2*DW-1:0] site_a_mem [128];
	logic [2*DW-1:0] site_b_mem [128];
	logic [2*DW-1:0] env_mem [64];

	mbec_pkg::op_t op_in;
	assign op_in = mbec_pkg::op_t'(op);
	logic accept;
	assign accept = start && !busy;

	always_ff @(posedge clk) begin
		if (accept && op_in == mbec_pkg::OP_SITE) begin
			site_a_mem[{phys_index, row_index, col_index}] <= {value_re, value_im};
			site_b_mem[{phys_index, row_index, col_index}] <= {value_re, value_im};
		end
		if (accept && op_in == mbec_pkg::OP_ENV)
			env_mem[{row_index, col_index}] <= {value_re, value_im};
	end

	// sequencer counters: i, j over the result, s, k, kp over the sum
	mbec_pkg::state_t state_q, state_d;
	logic [2:0] i_q, j_q, k_q, kp_q;
	logic s_q;
	logic [3:0] drain_q;
	logic k_end, kp_end, j_end, i_end, term_end, all_end;

	assign kp_end = (4'(kp_q) == inner_dim - 4'd1);
	assign k_end = (4'(k_q) == inner_dim - 4'd1);
	assign term_end = s_q && k_end && kp_end;
	assign j_end = (4'(j_q) == n_dim - 4'd1);
	assign i_end = (4'(i_q) == n_dim - 4'd1);
	assign all_end = term_end && i_end && j_end;

	always_comb begin
		state_d = state_q;
		busy = 1'b0;
		unique case (state_q)
			mbec_pkg::ST_IDLE: begin
				if (accept && op_in == mbec_pkg::OP_START) state_d = mbec_pkg::ST_READ;
			end
			mbec_pkg::ST_READ: begin
				busy = 1'b1;
				if (all_end) state_d = mbec_pkg::ST_DRAIN;
			end
			mbec_pkg::ST_DRAIN: begin
				busy = 1'b1;
				if (drain_q == 4'd0) state_d = mbec_pkg::ST_IDLE;
			end
			default: state_d = mbec_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mbec_pkg::ST_IDLE;
			i_q <= '0; j_q <= '0; k_q <= '0; kp_q <= '0; s_q <= 1'b0;
			drain_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == mbec_pkg::ST_IDLE) begin
				i_q <= '0; j_q <= '0; k_q <= '0; kp_q <= '0; s_q <= 1'b0;
				drain_q <= 4'd10;
			end else if (state_q == mbec_pkg::ST_READ) begin
				// innermost kp, then k, then s, then j, then i
				if (kp_end) begin
					kp_q <= '0;
					if (k_end) begin
						k_q <= '0;
						s_q <= ~s_q;
						if (s_q) begin
							if (j_end) begin
								j_q <= '0;
								i_q <= i_q + 3'd1;
							end else j_q <= j_q + 3'd1;
						end
					end else k_q <= k_q + 3'd1;
				end else kp_q <= kp_q + 3'd1;
			end else begin
				drain_q <= drain_q - 4'd1;
			end
		end
	end

	// read addresses and registered memory reads
	logic [6:0] xa, ya;
	assign xa = direction_q ? {s_q, k_q, i_q} : {s_q, i_q, k_q};
	assign ya = direction_q ? {s_q, kp_q, j_q} : {s_q, j_q, kp_q};

	logic [2*DW-1:0] x_s1, y_s1, m_s1, m_s2, m_s3;
	mbec_pkg::tag_t tag0_s1, tag_chain1;

	always_ff @(posedge clk) begin
		x_s1 <= site_a_mem[xa];
		y_s1 <= site_b_mem[ya];
		m_s1 <= env_mem[{k_q, kp_q}];
		// environment element rides alongside the first cell's latency
		m_s2 <= m_s1;
		m_s3 <= m_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tag0_s1 <= '0;
		else begin
			tag0_s1.valid <= (state_q == mbec_pkg::ST_READ);
			tag0_s1.first <= !s_q && k_q == 3'd0 && kp_q == 3'd0;
			tag0_s1.final_term <= term_end;
			tag0_s1.last <= all_end;
			tag0_s1.row <= i_q;
			tag0_s1.col <= j_q;
		end
	end

	logic signed [PW1-1:0] pr, pi;
	logic signed [PW2-1:0] tr, ti;
	mbec_pkg::tag_t tag_chain2;

	// first cell: x * conj(y)
	mbec_cell #(.AW(DW), .BW(DW), .PW(PW1), .CONJ_B(1'b1)) u_cell0 (
		.clk(clk), .arst_n(arst_n), .tag_in(tag0_s1),
		.a_re(x_s1[2*DW-1:DW]), .a_im(x_s1[DW-1:0]),
		.b_re(y_s1[2*DW-1:DW]), .b_im(y_s1[DW-1:0]),
		.tag_out(tag_chain1), .p_re(pr), .p_im(pi)
	);

	// second cell: times environment element
	mbec_cell #(.AW(PW1), .BW(DW), .PW(PW2), .CONJ_B(1'b0)) u_cell1 (
		.clk(clk), .arst_n(arst_n), .tag_in(tag_chain1),
		.a_re(pr), .a_im(pi),
		.b_re(m_s3[2*DW-1:DW]), .b_im(m_s3[DW-1:0]),
		.tag_out(tag_chain2), .p_re(tr), .p_im(ti)
	);

	mbec_acc #(.PW(PW2), .SHIFT(SHIFT)) u_acc (
		.clk(clk), .arst_n(arst_n), .tag_in(tag_chain2),
		.t_re(tr), .t_im(ti),
		.done(done), .out_row(out_row), .out_col(out_col),
		.out_re(out_re), .out_im(out_im), .last(last)
	);
endmodule
`default_nettype wire
